// ===== sv/tsv_pkg.sv =====
// ============================================================================
// tsv_pkg: shared types and constants of the timestamp format validator
// Holds the character layout of the timestamp, the parse state record and
// the decode functions used by the character check.
// ============================================================================
package tsv_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned PosW   = 5;
	localparam int unsigned ValueW = 14;
	localparam int unsigned NumSep = 6;
	localparam int unsigned SepIdxW = 3;

	// Layout positions that matter outside the tables.
	localparam logic [PosW-1:0] TsLen   = 5'd25;
	localparam logic [PosW-1:0] ZuluPos = 5'd19;
	localparam logic [PosW-1:0] LastPos = 5'd24;
	localparam logic [PosW-1:0] PosMax  = 5'd31;

	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;
	localparam logic [CharW-1:0] ChZulu  = 8'h5A;
	localparam logic [CharW-1:0] ChPlus  = 8'h2B;
	localparam logic [CharW-1:0] ChMinus = 8'h2D;
	localparam logic [CharW-1:0] ChTee   = 8'h54;
	localparam logic [CharW-1:0] ChColon = 8'h3A;

	// Register indexes of the separator bank.
	typedef enum logic [SepIdxW-1:0] {
		SEP_AFTER_YEAR   = 3'd0,
		SEP_AFTER_MONTH  = 3'd1,
		SEP_DATE_TIME    = 3'd2,
		SEP_AFTER_HOUR   = 3'd3,
		SEP_AFTER_MINUTE = 3'd4,
		SEP_IN_OFFSET    = 3'd5
	} sep_idx_t;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_SEP   = 2'd1,
		KIND_ZONE  = 2'd2
	} pos_kind_t;

	typedef logic [NumSep-1:0][CharW-1:0] sep_bank_t;

	typedef struct packed {
		logic [PosW-1:0]   pos;
		logic [ValueW-1:0] value;
		logic              failed;
		logic              zulu;
	} parse_state_t;

	localparam parse_state_t StateClear = '{pos: '0, value: '0, failed: 1'b0, zulu: 1'b0};

	// What kind of character belongs at a position of the layout.
	function automatic pos_kind_t kind_of(input logic [PosW-1:0] p);
		pos_kind_t k;
		k = KIND_DIGIT;
		case (p)
			5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd22: k = KIND_SEP;
			5'd19: k = KIND_ZONE;
			default: k = KIND_DIGIT;
		endcase
		return k;
	endfunction

	// Which separator register is compared at a separator position.
	function automatic sep_idx_t sep_of(input logic [PosW-1:0] p);
		sep_idx_t s;
		s = SEP_AFTER_YEAR;
		case (p)
			5'd7:  s = SEP_AFTER_MONTH;
			5'd10: s = SEP_DATE_TIME;
			5'd13: s = SEP_AFTER_HOUR;
			5'd16: s = SEP_AFTER_MINUTE;
			5'd22: s = SEP_IN_OFFSET;
			default: s = SEP_AFTER_YEAR;
		endcase
		return s;
	endfunction

	// Upper limit checked at the final digit of a field; the top bit marks
	// that the position closes a field.
	function automatic logic [ValueW:0] limit_of(input logic [PosW-1:0] p);
		logic [ValueW:0] l;
		l = '0;
		case (p)
			5'd3:  l = {1'b1, 14'd9999};
			5'd6:  l = {1'b1, 14'd12};
			5'd9:  l = {1'b1, 14'd31};
			5'd12: l = {1'b1, 14'd23};
			5'd15: l = {1'b1, 14'd59};
			5'd18: l = {1'b1, 14'd59};
			5'd21: l = {1'b1, 14'd23};
			5'd24: l = {1'b1, 14'd59};
			default: l = '0;
		endcase
		return l;
	endfunction

endpackage

// ===== sv/timestamp_format_validator_unit.sv =====
// ============================================================================
// timestamp_format_validator_unit: streaming timestamp format checker
// Reads a timestamp one character per word and, on the word marked last,
// returns one word that says whether the string is a valid timestamp.
// ============================================================================
// A verdict passes through the input register, then the result register.
// Throughput: one character per cycle; only a last character waits, while
// the result register holds an untaken word.
// Reset: arst_n clears the parse state, both valid flags and loads the
// separator registers with '-', '-', 'T', ':', ':', ':'.
module timestamp_format_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Character stream in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	// Verdict stream out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] timestamp_valid, [7:1] zero
	// Separator configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tsv_pkg::sep_bank_t    seps;
	tsv_pkg::parse_state_t state_q;
	tsv_pkg::parse_state_t state_nxt;
	logic                  verdict;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       fire;

	logic       out_valid_q;
	logic       out_bit_q;

	tsv_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seps    (seps)
	);

	tsv_char_check u_check (
		.char_code (char_s1),
		.cur       (state_q),
		.seps      (seps),
		.nxt       (state_nxt),
		.ok        (verdict)
	);

	// The registered character is consumed whenever it does not need the
	// result register, or the result register is free or being emptied.
	// A character that is not the last one never waits on the master side.
	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Parse state advances on every consumed character and starts over once
	// a string has been closed by its last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsv_pkg::StateClear;
		end else if (fire) begin
			state_q <= last_s1 ? tsv_pkg::StateClear : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			out_bit_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_bit_q};

`ifndef ASSERT_OFF
	// Closing a string always leaves a clean parse state behind.
	property p_clear_after_last;
		@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (state_q.pos == '0) && !state_q.failed && !state_q.zulu;
	endproperty
	a_clear_after_last: assert property (p_clear_after_last)
		else $error("parse state not cleared after last character");

	// A consumed middle character moves the position up by one until it saturates.
	property p_pos_step;
		@(posedge clk) disable iff (!arst_n)
		(fire && !last_s1 && (state_q.pos != tsv_pkg::PosMax)) |=>
			(state_q.pos == $past(state_q.pos) + 5'd1);
	endproperty
	a_pos_step: assert property (p_pos_step)
		else $error("character position did not advance by one");

	// A verdict only appears because a last character was consumed.
	property p_no_spurious_result;
		@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !(fire && last_s1)) |=> !out_valid_q;
	endproperty
	a_no_spurious_result: assert property (p_no_spurious_result)
		else $error("result word raised without a last character");

	// The Z flag can only be set once the zone position has been passed.
	property p_zulu_pos;
		@(posedge clk) disable iff (!arst_n)
		state_q.zulu |-> (state_q.pos > tsv_pkg::ZuluPos);
	endproperty
	a_zulu_pos: assert property (p_zulu_pos)
		else $error("zone flag set before the zone position");
`endif

endmodule

// ===== sv/tsv_cfg_regs.sv =====
// ============================================================================
// tsv_cfg_regs: separator register bank behind an APB-style port
// Six 8-bit separator registers at word addresses; writes beyond the bank
// are dropped and read back as zero.
// ============================================================================
module tsv_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output tsv_pkg::sep_bank_t seps
);

	tsv_pkg::sep_bank_t seps_q;
	logic [tsv_pkg::SepIdxW-1:0] idx;
	logic wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign seps   = seps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seps_q[tsv_pkg::SEP_AFTER_YEAR]   <= tsv_pkg::ChMinus;
			seps_q[tsv_pkg::SEP_AFTER_MONTH]  <= tsv_pkg::ChMinus;
			seps_q[tsv_pkg::SEP_DATE_TIME]    <= tsv_pkg::ChTee;
			seps_q[tsv_pkg::SEP_AFTER_HOUR]   <= tsv_pkg::ChColon;
			seps_q[tsv_pkg::SEP_AFTER_MINUTE] <= tsv_pkg::ChColon;
			seps_q[tsv_pkg::SEP_IN_OFFSET]    <= tsv_pkg::ChColon;
		end else if (wr_en && (idx < 3'(tsv_pkg::NumSep))) begin
			seps_q[idx] <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx < 3'(tsv_pkg::NumSep)) begin
			prdata = {24'd0, seps_q[idx]};
		end
	end

endmodule

// ===== sv/tsv_char_check.sv =====
// ============================================================================
// tsv_char_check: one-character step of the timestamp parser
// Checks a character against the layout at the current position, folds a
// digit into the field value and gives the verdict if the string ends here.
// ============================================================================
module tsv_char_check (
	input  logic [7:0]              char_code,
	input  tsv_pkg::parse_state_t   cur,
	input  tsv_pkg::sep_bank_t      seps,
	output tsv_pkg::parse_state_t   nxt,
	output logic                    ok
);

	logic        is_digit;
	logic [3:0]  digit;
	logic [17:0] acc;
	logic [14:0] lim;
	logic        zulu_here;
	logic [7:0]  sep_char;

	always_comb begin
		is_digit  = (char_code >= tsv_pkg::ChZero) && (char_code <= tsv_pkg::ChNine);
		digit     = is_digit ? 4'(char_code - tsv_pkg::ChZero) : 4'd0;
		acc       = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0} + {14'd0, digit};
		lim       = tsv_pkg::limit_of(cur.pos);
		sep_char  = seps[tsv_pkg::sep_of(cur.pos)];
		zulu_here = 1'b0;
		nxt       = cur;

		if (cur.zulu || (cur.pos >= tsv_pkg::TsLen)) begin
			// Anything after a Z, or past the full length, spoils the string.
			nxt.failed = 1'b1;
		end else begin
			unique case (tsv_pkg::kind_of(cur.pos))
				tsv_pkg::KIND_DIGIT: begin
					if (!is_digit) nxt.failed = 1'b1;
					if (lim[14]) begin
						if (acc[13:0] > lim[13:0]) nxt.failed = 1'b1;
						nxt.value = '0;
					end else begin
						nxt.value = acc[13:0];
					end
				end
				tsv_pkg::KIND_SEP: begin
					if (char_code != sep_char) nxt.failed = 1'b1;
				end
				tsv_pkg::KIND_ZONE: begin
					if (char_code == tsv_pkg::ChZulu) begin
						zulu_here = 1'b1;
					end else if ((char_code != tsv_pkg::ChPlus) &&
						(char_code != tsv_pkg::ChMinus)) begin
						nxt.failed = 1'b1;
					end
				end
				default: nxt.failed = 1'b1;
			endcase
		end

		nxt.zulu = cur.zulu | zulu_here;
		if (cur.pos != tsv_pkg::PosMax) nxt.pos = cur.pos + 5'd1;

		ok = !nxt.failed &&
			((zulu_here && (cur.pos == tsv_pkg::ZuluPos)) ||
			(!nxt.zulu && (cur.pos == tsv_pkg::LastPos)));
	end

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: testbench of the timestamp format validator
// Streams timestamp strings one character per word into the block, predicts
// each verdict from its own copy of the parse state and separator bank, and
// compares every verdict word with the oldest prediction. Separators are
// rewritten between phases; both stream sides idle and stall at random.
// ============================================================================
class stamp_scoreboard;
	logic [tsv_pkg::CharW-1:0]  seps [tsv_pkg::NumSep];
	logic [tsv_pkg::PosW-1:0]   pos;
	logic [tsv_pkg::ValueW-1:0] value;
	bit                         failed;
	bit                         zulu;
	bit                         verdicts [$];
	int                         errors;

	function new();
		seps[tsv_pkg::SEP_AFTER_YEAR]   = tsv_pkg::ChMinus;
		seps[tsv_pkg::SEP_AFTER_MONTH]  = tsv_pkg::ChMinus;
		seps[tsv_pkg::SEP_DATE_TIME]    = tsv_pkg::ChTee;
		seps[tsv_pkg::SEP_AFTER_HOUR]   = tsv_pkg::ChColon;
		seps[tsv_pkg::SEP_AFTER_MINUTE] = tsv_pkg::ChColon;
		seps[tsv_pkg::SEP_IN_OFFSET]    = tsv_pkg::ChColon;
		errors = 0;
		restart();
	endfunction

	function void restart();
		pos    = '0;
		value  = '0;
		failed = 1'b0;
		zulu   = 1'b0;
	endfunction

	// Writes beyond the last separator register fall on nothing.
	function void set_sep(int idx, logic [tsv_pkg::CharW-1:0] v);
		if (idx < tsv_pkg::NumSep) seps[idx] = v;
	endfunction

	function tsv_pkg::pos_kind_t slot_kind(logic [tsv_pkg::PosW-1:0] p);
		if (p == tsv_pkg::ZuluPos) return tsv_pkg::KIND_ZONE;
		if (p == 4 || p == 7 || p == 10 || p == 13 || p == 16 || p == 22)
			return tsv_pkg::KIND_SEP;
		return tsv_pkg::KIND_DIGIT;
	endfunction

	function tsv_pkg::sep_idx_t slot_sep(logic [tsv_pkg::PosW-1:0] p);
		case (p)
			5'd4:    return tsv_pkg::SEP_AFTER_YEAR;
			5'd7:    return tsv_pkg::SEP_AFTER_MONTH;
			5'd10:   return tsv_pkg::SEP_DATE_TIME;
			5'd13:   return tsv_pkg::SEP_AFTER_HOUR;
			5'd16:   return tsv_pkg::SEP_AFTER_MINUTE;
			default: return tsv_pkg::SEP_IN_OFFSET;
		endcase
	endfunction

	// Upper bound checked at the closing digit of a field, -1 elsewhere.
	function int field_limit(logic [tsv_pkg::PosW-1:0] p);
		case (p)
			5'd3:               return 9999;
			5'd6:               return 12;
			5'd9:               return 31;
			5'd12, 5'd21:       return 23;
			5'd15, 5'd18, 5'd24: return 59;
			default:            return -1;
		endcase
	endfunction

	function void note_char(logic [tsv_pkg::CharW-1:0] c, bit last);
		logic [tsv_pkg::PosW-1:0] p;
		bit                       zulu_here;
		int                       acc;
		int                       lim;
		p = pos;
		zulu_here = 1'b0;
		if (zulu || p >= tsv_pkg::TsLen) begin
			failed = 1'b1;
		end else begin
			case (slot_kind(p))
				tsv_pkg::KIND_DIGIT: begin
					acc = 0;
					if (c >= tsv_pkg::ChZero && c <= tsv_pkg::ChNine) acc = c - tsv_pkg::ChZero;
					else failed = 1'b1;
					acc = value * 10 + acc;
					value = acc[tsv_pkg::ValueW-1:0];
					lim = field_limit(p);
					if (lim >= 0) begin
						if (value > lim) failed = 1'b1;
						value = '0;
					end
				end
				tsv_pkg::KIND_SEP: begin
					if (c != seps[slot_sep(p)]) failed = 1'b1;
				end
				default: begin
					if (c == tsv_pkg::ChZulu) zulu_here = 1'b1;
					else if (c != tsv_pkg::ChPlus && c != tsv_pkg::ChMinus) failed = 1'b1;
				end
			endcase
		end
		if (zulu_here) zulu = 1'b1;
		if (pos != tsv_pkg::PosMax) pos = pos + 1'b1;
		if (last) begin
			verdicts.push_back(!failed &&
				((zulu_here && p == tsv_pkg::ZuluPos) || (!zulu && p == tsv_pkg::LastPos)));
			restart();
		end
	endfunction

	function void check_verdict(logic [7:0] word);
		logic [7:0] want;
		if (verdicts.size() == 0) begin
			$display("%0t: verdict word %h with no string pending", $time, word);
			errors++;
		end else begin
			want = {7'b0, verdicts.pop_front()};
			if (word !== want) begin
				$display("%0t: verdict mismatch, expected %h, got %h", $time, want, word);
				errors++;
			end
		end
	endfunction
endclass

module tb;

	localparam int HoldCycles  = 300;
	localparam int PhaseChars  = 300;
	localparam int NumPhases   = 6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tlast;   // last_char
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] timestamp_valid, [7:1] zero
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	stamp_scoreboard sb = new();

	// Separators as the string builder sees them; kept in step with the bank.
	logic [7:0] sep_now [tsv_pkg::NumSep];
	// The string under construction.
	logic [7:0] text [$];
	// Turns off idling on both sides for a stretch.
	bit         calm = 1'b0;
	// Asks the receiver for one long hold-off.
	bit         hold_req = 1'b0;
	int         phase_chars;

	timestamp_format_validator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Both handshakes are sampled at the rising edge, before any of the
	// nonblocking updates of that edge land, so the words seen here are the
	// ones the block takes or gives at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
		end
	end

	// Receiver: random stalls, none while calm, and one long hold-off on
	// request so that the verdict path backs up and the block stops taking
	// characters. The hold-off is counted here, in the receiver's own process.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
			end
		end
	end

	// One character word. Valid stays high from one word to the next unless
	// an idle cycle is rolled, so it gets one assignment per time step.
	task automatic send_word(input logic [7:0] c, input bit last);
		while (!calm && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		phase_chars++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
	endtask

	// Register write: setup cycle, then the access cycle whose closing edge
	// stores the value. The bus is left selected so that back-to-back writes
	// do not touch psel twice in one step; bus_idle releases it.
	task automatic reg_write(input int idx, input logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx * 4);
		pwdata  <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_sep(idx, v);
		if (idx < tsv_pkg::NumSep) sep_now[idx] = v;
	endtask

	task automatic bus_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Let the monitor note the final character first, then wait until every
	// verdict is in, then give the pipeline time to settle before the
	// separators change.
	task automatic drain();
		@(posedge clk);
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Field values lean toward zero, the limit, one past it and all nines.
	function automatic int pick_field(input int lim, input int nd);
		int top;
		int v;
		top = (nd == 4) ? 9999 : 99;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = lim;
			2:       v = (lim < top) ? lim + 1 : lim;
			3:       v = top;
			default: v = $urandom_range(0, lim);
		endcase
		return v;
	endfunction

	task automatic put_num(input int v, input int nd);
		int div;
		div = 1;
		repeat (nd - 1) div *= 10;
		repeat (nd) begin
			text.push_back(8'(tsv_pkg::ChZero + (v / div) % 10));
			div /= 10;
		end
	endtask

	// A timestamp laid out under the current separators, its fields at times past
	// their limits, with the zone given either as Z or as a signed offset.
	task automatic build_stamp();
		text.delete();
		put_num(pick_field(9999, 4), 4);
		text.push_back(sep_now[tsv_pkg::SEP_AFTER_YEAR]);
		put_num(pick_field(12, 2), 2);
		text.push_back(sep_now[tsv_pkg::SEP_AFTER_MONTH]);
		put_num(pick_field(31, 2), 2);
		text.push_back(sep_now[tsv_pkg::SEP_DATE_TIME]);
		put_num(pick_field(23, 2), 2);
		text.push_back(sep_now[tsv_pkg::SEP_AFTER_HOUR]);
		put_num(pick_field(59, 2), 2);
		text.push_back(sep_now[tsv_pkg::SEP_AFTER_MINUTE]);
		put_num(pick_field(59, 2), 2);
		if ($urandom_range(0, 2) == 0) begin
			text.push_back(tsv_pkg::ChZulu);
		end else begin
			text.push_back($urandom_range(0, 1) ? tsv_pkg::ChPlus : tsv_pkg::ChMinus);
			put_num(pick_field(23, 2), 2);
			text.push_back(sep_now[tsv_pkg::SEP_IN_OFFSET]);
			put_num(pick_field(59, 2), 2);
		end
	endtask

	// Mostly timestamps with random content; some are broken on purpose and a
	// few are short runs of random bytes.
	task automatic build_string();
		int roll;
		int k;
		int n;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			text.delete();
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			build_stamp();
			if (roll < 45) begin
				k = $urandom_range(0, text.size() - 1);
				case ($urandom_range(0, 5))
					0: text[k] = 8'($urandom_range(0, 255));
					// Characters just outside the digit range.
					1: text[k] = $urandom_range(0, 1) ? 8'h2F : 8'h3A;
					2: begin
						n = $urandom_range(1, text.size() - 1);
						while (text.size() > n) void'(text.pop_back());
					end
					3: repeat ($urandom_range(1, 6))
						text.push_back(8'(tsv_pkg::ChZero + $urandom_range(0, 9)));
					// Often long enough to run the position counter into its ceiling.
					4: repeat ($urandom_range(10, 20))
						text.push_back(8'($urandom_range(0, 255)));
					// Z followed by an offset, or a sign with nothing after it.
					default: text[tsv_pkg::ZuluPos] =
						(text[tsv_pkg::ZuluPos] == tsv_pkg::ChZulu) ?
						tsv_pkg::ChPlus : tsv_pkg::ChZulu;
				endcase
			end
		end
	endtask

	// Separator settings per phase: reset values, all zeros, all ones,
	// random, the usual ones again with no idling, and random once more.
	task automatic configure(input int phase);
		logic [7:0] v;
		for (int i = 0; i < tsv_pkg::NumSep + 2; i++) begin
			case (phase)
				1:       v = 8'h00;
				2:       v = 8'hFF;
				4:       v = (i < 2) ? tsv_pkg::ChMinus :
					(i == 2) ? tsv_pkg::ChTee : tsv_pkg::ChColon;
				default: v = 8'($urandom_range(0, 255));
			endcase
			reg_write(i, v);
		end
		bus_idle();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		sep_now[tsv_pkg::SEP_AFTER_YEAR]   = tsv_pkg::ChMinus;
		sep_now[tsv_pkg::SEP_AFTER_MONTH]  = tsv_pkg::ChMinus;
		sep_now[tsv_pkg::SEP_DATE_TIME]    = tsv_pkg::ChTee;
		sep_now[tsv_pkg::SEP_AFTER_HOUR]   = tsv_pkg::ChColon;
		sep_now[tsv_pkg::SEP_AFTER_MINUTE] = tsv_pkg::ChColon;
		sep_now[tsv_pkg::SEP_IN_OFFSET]    = tsv_pkg::ChColon;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every field at its upper limit with a negative offset, then a lone
		// Z, which ends the string far too early.
		text = '{"9", "9", "9", "9", "-", "1", "2", "-", "3", "1", "T", "2", "3", ":",
			"5", "9", ":", "5", "9", "-", "2", "3", ":", "5", "9"};
		send_text();
		text = '{tsv_pkg::ChZulu};
		send_text();

		for (int phase = 0; phase < NumPhases; phase++) begin
			s_tvalid <= 1'b0;
			drain();
			if (phase != 0) configure(phase);
			calm = (phase == 4);
			if (phase == 2) hold_req = 1'b1;
			phase_chars = 0;
			while (phase_chars < PhaseChars) begin
				build_string();
				send_text();
			end
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;
		drain();
		repeat (4) @(posedge clk);

		if (sb.verdicts.size() != 0)
			$display("%0t: %0d verdicts never arrived", $time, sb.verdicts.size());
		if (sb.errors == 0 && sb.verdicts.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Far beyond the slowest correct run, hold-off and all.
	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
